// ===== sv/onewire_rom_search_macros.svh =====
// assertion macros shared by the rom search rtl
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// checked while out of reset
`define OWRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define OWRS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/owrs_pkg.sv =====
// types and constants of the rom search engine
`default_nettype none

package owrs_pkg;

  localparam int unsigned ADDR_OUT_W   = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned FAM_W        = 4;
  localparam int unsigned FAMILY_LIMIT = 9;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;

  localparam logic [1:0] STATUS_CONTINUE = 2'd0;
  localparam logic [1:0] STATUS_FOUND    = 2'd1;
  localparam logic [1:0] STATUS_FAILED   = 2'd2;
  localparam logic [1:0] STATUS_IGNORED  = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } owrs_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  direction;
    logic                  direction_valid;
    logic [ADDR_OUT_W-1:0] address;
    logic                  is_last_device;
    logic [FAM_W-1:0]      family_discrepancy;
  } owrs_out_t;

  // search bookkeeping carried from item to item
  typedef struct packed {
    logic             pass_active;
    logic             last_device;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] last_disc;
    logic [POS_W-1:0] zero_pos;
    logic [FAM_W-1:0] family_disc;
  } owrs_ctrl_t;

  localparam owrs_ctrl_t CTRL_RESET = '{
    pass_active: 1'b0,
    last_device: 1'b0,
    bit_pos:     POS_W'(1),
    last_disc:   '0,
    zero_pos:    '0,
    family_disc: '0
  };

endpackage

`default_nettype wire

// ===== sv/owrs_step.sv =====
// next search state and result for one item
`default_nettype none

module owrs_step #(
  parameter int unsigned ADDRESS_BITS = 64
) (
  input  owrs_pkg::owrs_in_t        item_i,
  input  owrs_pkg::owrs_ctrl_t      ctrl_i,
  input  logic [ADDRESS_BITS-1:0]   rom_i,
  output owrs_pkg::owrs_ctrl_t      ctrl_o,
  output logic [ADDRESS_BITS-1:0]   rom_o,
  output owrs_pkg::owrs_out_t       res_o
);
  import owrs_pkg::*;

  localparam int unsigned IdxW = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
  localparam logic [POS_W-1:0] LastPos = POS_W'(ADDRESS_BITS);
  localparam logic [POS_W-1:0] FamLimit = POS_W'(FAMILY_LIMIT);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_m1;
  logic [IdxW-1:0]  idx;
  logic             dir;
  logic             is_discrepancy;

  assign pos            = ctrl_i.bit_pos;
  assign pos_m1         = pos - POS_W'(1);
  assign idx            = pos_m1[IdxW-1:0];
  assign is_discrepancy = !item_i.id_bit && !item_i.complement_bit;

  always_comb begin
    if (!is_discrepancy) begin
      dir = item_i.id_bit;
    end else if (pos < ctrl_i.last_disc) begin
      dir = rom_i[idx];
    end else begin
      dir = (pos == ctrl_i.last_disc);
    end
  end

  always_comb begin
    ctrl_o                    = ctrl_i;
    rom_o                     = rom_i;
    res_o.status              = STATUS_IGNORED;
    res_o.direction           = 1'b0;
    res_o.direction_valid     = 1'b0;

    case (item_i.opcode)
      OP_CLEAR: begin
        ctrl_o       = CTRL_RESET;
        rom_o        = '0;
        res_o.status = STATUS_CONTINUE;
      end
      OP_START: begin
        ctrl_o.bit_pos  = POS_W'(1);
        ctrl_o.zero_pos = '0;
        if (ctrl_i.last_device || !item_i.presence) begin
          ctrl_o.last_disc   = '0;
          ctrl_o.family_disc = '0;
          ctrl_o.last_device = 1'b0;
          ctrl_o.pass_active = 1'b0;
          res_o.status       = STATUS_FAILED;
        end else begin
          ctrl_o.pass_active = 1'b1;
          res_o.status       = STATUS_CONTINUE;
        end
      end
      OP_PAIR: begin
        if (ctrl_i.pass_active) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            ctrl_o.last_disc   = '0;
            ctrl_o.family_disc = '0;
            ctrl_o.last_device = 1'b0;
            ctrl_o.pass_active = 1'b0;
            res_o.status       = STATUS_FAILED;
          end else begin
            if (is_discrepancy && !dir) begin
              ctrl_o.zero_pos = pos;
              if (pos < FamLimit) begin
                ctrl_o.family_disc = pos[FAM_W-1:0];
              end
            end
            rom_o[idx]            = dir;
            res_o.direction       = dir;
            res_o.direction_valid = 1'b1;
            if (pos >= LastPos) begin
              ctrl_o.pass_active = 1'b0;
              ctrl_o.bit_pos     = POS_W'(1);
              ctrl_o.last_disc   = ctrl_o.zero_pos;
              if (ctrl_o.zero_pos == '0) begin
                ctrl_o.last_device = 1'b1;
              end
              // an all-zero family byte means nothing real answered
              if (rom_o[7:0] == 8'h00) begin
                ctrl_o.last_disc   = '0;
                ctrl_o.family_disc = '0;
                ctrl_o.last_device = 1'b0;
                res_o.status       = STATUS_FAILED;
              end else begin
                res_o.status = STATUS_FOUND;
              end
            end else begin
              ctrl_o.bit_pos = pos + POS_W'(1);
              res_o.status   = STATUS_CONTINUE;
            end
          end
        end
      end
      default: begin
        res_o.status = STATUS_IGNORED;
      end
    endcase

    res_o.address            = ADDR_OUT_W'(rom_o);
    res_o.is_last_device     = ctrl_o.last_device;
    res_o.family_discrepancy = ctrl_o.family_disc;
  end

endmodule

`default_nettype wire

// ===== sv/onewire_rom_search.sv =====
// 1-wire rom search engine: takes clear, start-pass and bit-pair items and
// walks the device id tree one bit per item, choosing the bit the host writes
// back and keeping the discrepancy markers that let successive passes list
// every device. One item is accepted per clock while the result slot is free or
// being drained; each item gives exactly one result, held in the input register
// and then the result register, and the step logic that updates the search state
// sets that rate. ADDRESS_BITS (8 to 64) sets the id length; the address field
// is always 64 bits wide with the unused upper bits at zero.
`default_nettype none
`include "onewire_rom_search_macros.svh"

module onewire_rom_search #(
  parameter int unsigned ADDRESS_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  owrs_pkg::owrs_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output owrs_pkg::owrs_out_t out_o
);
  import owrs_pkg::*;

  logic                    in_valid_q;
  owrs_in_t                item_q;
  logic                    out_valid_q;
  owrs_out_t               out_q;
  owrs_ctrl_t              ctrl_q;
  owrs_ctrl_t              ctrl_d;
  logic [ADDRESS_BITS-1:0] rom_q;
  logic [ADDRESS_BITS-1:0] rom_d;
  owrs_out_t               res_d;
  logic                    advance;
  logic                    in_xfer;

  // the held item moves on when the result slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  owrs_step #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_step (
    .item_i (item_q),
    .ctrl_i (ctrl_q),
    .rom_i  (rom_q),
    .ctrl_o (ctrl_d),
    .rom_o  (rom_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= CTRL_RESET;
      rom_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        ctrl_q      <= ctrl_d;
        rom_q       <= rom_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `OWRS_ASSERT(a_bit_pos_range,
    (ctrl_q.bit_pos != '0) && (ctrl_q.bit_pos <= POS_W'(ADDRESS_BITS)),
    "bit position out of range")
  `OWRS_ASSERT(a_last_disc_range,
    ctrl_q.last_disc <= POS_W'(ADDRESS_BITS),
    "last discrepancy beyond address length")
  `OWRS_ASSERT(a_ignored_no_dir,
    out_valid_q && (out_q.status == STATUS_IGNORED) |-> !out_q.direction_valid,
    "ignored item drives a direction")
  `OWRS_ASSERT(a_item_held,
    in_valid_q && !advance |=> in_valid_q && $stable(item_q),
    "stalled item lost from input register")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the rom search engine: bus of simulated devices, scoreboard with predictor
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import owrs_pkg::*;

  localparam int unsigned ID_BITS      = 64;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned TARGET_ITEMS = 900;
  localparam int unsigned MAX_REPORTS  = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  owrs_in_t  in_item;
  logic      out_valid;
  logic      out_ready;
  owrs_out_t out_item;

  bit          burst_mode;
  int unsigned n_items;
  int unsigned n_useful;
  int unsigned n_sessions;

  logic [63:0] bus_ids[$];
  bit          alive[$];

  // search state mirror, expected results in transfer order
  class search_scoreboard;
    logic [63:0]      rom;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] last_disc;
    logic [POS_W-1:0] zero_pos;
    logic [FAM_W-1:0] family_disc;
    logic             last_dev;
    logic             pass_on;
    owrs_out_t        results_due[$];
    int unsigned      n_checked;
    int unsigned      n_bad;
    int unsigned      n_found;
    int unsigned      n_failed;
    int unsigned      n_disc;

    function new();
      reset_search();
    endfunction

    function void reset_search();
      rom = '0;
      bit_pos = POS_W'(1);
      zero_pos = '0;
      pass_on = 1'b0;
      drop_flags();
    endfunction

    function void drop_flags();
      last_disc = '0;
      family_disc = '0;
      last_dev = 1'b0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function owrs_out_t predict_item(owrs_in_t it);
      owrs_out_t        r;
      logic [POS_W-1:0] pos;
      logic [5:0]       idx;
      logic             dir;
      r = '0;
      case (it.opcode)
        OP_CLEAR: begin
          reset_search();
          r.status = STATUS_CONTINUE;
        end
        OP_START: begin
          bit_pos = POS_W'(1);
          zero_pos = '0;
          if (last_dev || !it.presence) begin
            drop_flags();
            pass_on = 1'b0;
            r.status = STATUS_FAILED;
          end else begin
            pass_on = 1'b1;
            r.status = STATUS_CONTINUE;
          end
        end
        OP_PAIR: begin
          if (!pass_on) begin
            r.status = STATUS_IGNORED;
          end else if (it.id_bit && it.complement_bit) begin
            drop_flags();
            pass_on = 1'b0;
            r.status = STATUS_FAILED;
          end else begin
            pos = bit_pos;
            idx = 6'(pos - 1);
            if (it.id_bit != it.complement_bit) begin
              dir = it.id_bit;
            end else begin
              // both branches present on the bus
              n_disc++;
              if (pos < last_disc) dir = rom[idx];
              else dir = (pos == last_disc);
              if (!dir) begin
                zero_pos = pos;
                if (pos < FAMILY_LIMIT) family_disc = pos[FAM_W-1:0];
              end
            end
            rom[idx] = dir;
            r.direction = dir;
            r.direction_valid = 1'b1;
            if (pos >= ID_BITS) begin
              pass_on = 1'b0;
              bit_pos = POS_W'(1);
              last_disc = zero_pos;
              if (last_disc == '0) last_dev = 1'b1;
              if (rom[7:0] == 8'h00) begin
                drop_flags();
                r.status = STATUS_FAILED;
              end else begin
                r.status = STATUS_FOUND;
              end
            end else begin
              bit_pos = pos + POS_W'(1);
              r.status = STATUS_CONTINUE;
            end
          end
        end
        default: r.status = STATUS_IGNORED;
      endcase
      r.address = rom;
      r.is_last_device = last_dev;
      r.family_discrepancy = family_disc;
      if (r.status == STATUS_FOUND) n_found++;
      if (r.status == STATUS_FAILED) n_failed++;
      results_due.insert(results_due.size(), r);
      return r;
    endfunction

    function void check_result(owrs_out_t got);
      owrs_out_t e;
      n_checked++;
      if (results_due.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("tb: result %0d with nothing pending: st=%0d addr=%h", n_checked,
                   got.status, got.address);
        return;
      end
      e = results_due.pop_front();
      if (got.status !== e.status || got.direction !== e.direction ||
          got.direction_valid !== e.direction_valid || got.address !== e.address ||
          got.is_last_device !== e.is_last_device ||
          got.family_discrepancy !== e.family_discrepancy) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("tb: result %0d mismatch, exp st=%0d dir=%b dv=%b addr=%h last=%b fam=%0d",
                   n_checked, e.status, e.direction, e.direction_valid, e.address,
                   e.is_last_device, e.family_discrepancy);
          $display("tb:                        got st=%0d dir=%b dv=%b addr=%h last=%b fam=%0d",
                   got.status, got.direction, got.direction_valid, got.address,
                   got.is_last_device, got.family_discrepancy);
        end
      end
    endfunction
  endclass

  search_scoreboard sb = new();

  onewire_rom_search #(
    .ADDRESS_BITS(ID_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_item);
  end

  function automatic owrs_in_t mk(logic [1:0] op, logic pres, logic idb, logic cmp);
    owrs_in_t it;
    it.opcode = op;
    it.presence = pres;
    it.id_bit = idb;
    it.complement_bit = cmp;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input owrs_in_t it, output owrs_out_t res);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
    res = sb.predict_item(it);
    n_items++;
    if (res.status != STATUS_IGNORED) n_useful++;
  endtask

  // the last transfer is already taken, so valid drops before waiting
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // one enumeration over a small set of devices sharing most of their id
  task automatic run_search(input bit zero_family);
    int unsigned n_dev;
    int unsigned passes;
    logic [63:0] base;
    logic [63:0] id;
    logic        id_b;
    logic        cp_b;
    owrs_out_t   e;
    bus_ids.delete();
    base = {$urandom(), $urandom()};
    if (zero_family || $urandom_range(0, 5) == 0) base[7:0] = 8'h00;
    n_dev = zero_family ? 1 : $urandom_range(1, 4);
    repeat (n_dev) begin
      id = base;
      if (!zero_family && $urandom_range(0, 1)) id ^= 64'd1 << $urandom_range(0, 7);
      if (!zero_family && $urandom_range(0, 1)) id ^= 64'd1 << $urandom_range(0, 7);
      if (!zero_family && $urandom_range(0, 2) == 0) id ^= 64'd1 << $urandom_range(8, 63);
      bus_ids.insert(bus_ids.size(), id);
    end
    if ($urandom_range(0, 7) != 0)
      send_item(mk(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1)), e);
    passes = 0;
    while (1) begin
      send_item(mk(OP_START, 1'b1, $urandom_range(0, 1), $urandom_range(0, 1)), e);
      if (e.status != STATUS_CONTINUE) break;
      alive.delete();
      foreach (bus_ids[k]) alive.insert(alive.size(), 1'b1);
      for (int b = 0; b < ID_BITS; b++) begin
        // wired-and of every device still on the path
        id_b = 1'b1;
        cp_b = 1'b1;
        foreach (bus_ids[k]) begin
          if (alive[k]) begin
            if (bus_ids[k][b]) cp_b = 1'b0;
            else id_b = 1'b0;
          end
        end
        if ($urandom_range(0, 499) == 0) begin
          id_b = 1'b1;
          cp_b = 1'b1;
        end
        send_item(mk(OP_PAIR, $urandom_range(0, 1), id_b, cp_b), e);
        foreach (bus_ids[k]) if (bus_ids[k][b] != e.direction) alive[k] = 1'b0;
        if (e.status != STATUS_CONTINUE) break;
      end
      passes++;
      if (e.status != STATUS_FOUND || passes > n_dev + 1) break;
    end
  endtask

  // receiver side, with one long hold-off once traffic is flowing
  initial begin
    int unsigned stall;
    int unsigned r;
    bit          held;
    stall = 0;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.n_checked >= 150) begin
        held = 1'b1;
        stall = 120;
      end
      r = $urandom_range(0, 99);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (burst_mode || r >= 28) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall = (r < 4) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    owrs_out_t e;
    in_valid = 1'b0;
    in_item = '0;
    rst_ni = 1'b0;
    burst_mode = 1'b0;
    n_items = 0;
    n_useful = 0;
    n_sessions = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: ignored items, a failing start, restart, every pair kind, clear
    send_item(mk(OP_PAIR, 1'b0, 1'b1, 1'b0), e);
    send_item(mk(OP_UNUSED, 1'b0, 1'b0, 1'b0), e);
    send_item(mk(OP_START, 1'b0, 1'b0, 1'b0), e);
    send_item(mk(OP_START, 1'b1, 1'b0, 1'b0), e);
    send_item(mk(OP_PAIR, 1'b0, 1'b1, 1'b1), e);
    send_item(mk(OP_PAIR, 1'b1, 1'b0, 1'b0), e);
    send_item(mk(OP_START, 1'b1, 1'b1, 1'b1), e);
    send_item(mk(OP_PAIR, 1'b0, 1'b1, 1'b0), e);
    send_item(mk(OP_PAIR, 1'b1, 1'b0, 1'b1), e);
    send_item(mk(OP_PAIR, 1'b0, 1'b0, 1'b0), e);
    send_item(mk(OP_PAIR, 1'b1, 1'b0, 1'b0), e);
    send_item(mk(OP_START, 1'b1, 1'b0, 1'b1), e);
    send_item(mk(OP_PAIR, 1'b1, 1'b0, 1'b0), e);
    send_item(mk(OP_PAIR, 1'b0, 1'b1, 1'b0), e);
    send_item(mk(OP_CLEAR, 1'b1, 1'b1, 1'b1), e);
    send_item(mk(OP_PAIR, 1'b0, 1'b0, 1'b0), e);
    send_item(mk(OP_UNUSED, 1'b1, 1'b1, 1'b1), e);
    send_item(mk(OP_CLEAR, 1'b0, 1'b0, 1'b0), e);
    drain();

    while (n_useful < TARGET_ITEMS) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 3))
        send_item(mk(2'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1)), e);
      run_search(n_sessions == 0);
      n_sessions++;
      if (n_sessions % 6 == 5) drain();
    end
    burst_mode = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    $display("tb: %0d items sent over %0d searches, %0d results checked", n_items,
             n_sessions, sb.n_checked);
    $display("tb: %0d devices found, %0d failed passes, %0d discrepancies resolved",
             sb.n_found, sb.n_failed, sb.n_disc);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
